>>> sv/csvp_pkg.sv
// Shared types and constants for the CSV line field parser.
// Used by csvp_parse, csvp_rsp_queue and csv_line_field_parser_core; no dependencies.
`default_nettype none

package csvp_pkg;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [7:0] MAX_FIELDS_RESET = 8'd16;

   // Result queue depth; a power of two so that the pointers wrap naturally.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] byte_out;
      logic       field_done;
      logic [7:0] field_number;
      logic       line_done;
      logic       parse_error;
   } result_type;

   // Results produced by one input beat, in order; num is 0, 1 or 2.
   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

>>> sv/csv_line_field_parser_core.sv
// Channel   Ports                                   Direction  Beat
// req       req_valid/req_ready, req_char_in,       in         one line byte or empty line
//           req_line_last, req_empty_line
// rsp       rsp_valid/rsp_ready, rsp_byte_valid ..  out        one field byte or mark
// csr       csr_write, csr_wdata                    in         max_fields write
//
// A byte is registered, parsed combinationally against the line state and its zero, one
// or two results land in a four-entry result queue; one result leaves per cycle while
// rsp_ready is high. Sustained rate is one req beat per cycle while the queue drains; a
// beat that makes two results waits only while the queue lacks room for both.
// Reset is synchronous and clears the line state, queue and max_fields (to 16).
// rsp stalls back up through the queue into the input register and then req_ready.
// Top level of the CSV line field parser; depends on csvp_pkg, csvp_parse, csvp_rsp_queue.
`default_nettype none

module csv_line_field_parser_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire  [7:0] req_char_in,
   input  wire        req_line_last,
   input  wire        req_empty_line,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_field_done,
   output logic [7:0] rsp_field_number,
   output logic       rsp_line_done,
   output logic       rsp_parse_error,
   input  wire        csr_write,
   input  wire  [7:0] csr_wdata
);
   import csvp_pkg::*;

   logic [7:0]           max_fields_ff;
   push_type             push;
   logic [RSP_CNT_W-1:0] rsp_space;
   result_type           rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fields_ff <= MAX_FIELDS_RESET;
      end else if (csr_write) begin
         max_fields_ff <= csr_wdata;
      end
   end

   csvp_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_in    (req_char_in),
      .req_line_last  (req_line_last),
      .req_empty_line (req_empty_line),
      .max_fields     (max_fields_ff),
      .rsp_space      (rsp_space),
      .push           (push)
   );

   csvp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_space (rsp_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_byte_valid   = rsp_data.byte_valid;
   assign rsp_byte_out     = rsp_data.byte_out;
   assign rsp_field_done   = rsp_data.field_done;
   assign rsp_field_number = rsp_data.field_number;
   assign rsp_line_done    = rsp_data.line_done;
   assign rsp_parse_error  = rsp_data.parse_error;

`ifndef SYNTHESIS
   // The queue is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat present right after reset");

   // Only a content byte carries a nonzero byte value.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_byte_out == 8'd0)
      else $error("byte_out nonzero without byte_valid");

   // A completed field is always counted.
   a_field_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_done |-> rsp_field_number != 8'd0)
      else $error("field_done with field_number zero");

   // Content bytes never report an error.
   a_byte_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_parse_error)
      else $error("content byte flagged as error");

   // The queue never takes more results than it has room for.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.num != 2'd0 |-> {{(RSP_CNT_W-2){1'b0}}, push.num} <= rsp_space)
      else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

>>> sv/csvp_parse.sv
// Input register, parser state and the single-pass parse logic of one byte.
// Depends on csvp_pkg.
`default_nettype none

module csvp_parse (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [7:0]                     req_char_in,
   input  wire                            req_line_last,
   input  wire                            req_empty_line,
   input  wire  [7:0]                     max_fields,
   input  wire  [csvp_pkg::RSP_CNT_W-1:0] rsp_space,
   output csvp_pkg::push_type             push
);
   import csvp_pkg::*;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_PLAIN  = 3'd1,
      PH_QUOTED = 3'd2,
      PH_QSEEN  = 3'd3,
      PH_CLOSED = 3'd4
   } phase_type;

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       empty_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] seen_ff, seen_in;
   logic       err_ff, err_in;

   result_type res_a, res_b;
   logic       a_vld, b_vld;
   logic       emit_byte, field_end, raise_a;
   phase_type  phase1;
   logic [7:0] seen1, seen2;
   logic       err1, err2;
   logic [1:0] num;
   logic       fire;
   logic       take;

   always_comb begin
      res_a     = '0;
      res_b     = '0;
      a_vld     = 1'b0;
      b_vld     = 1'b0;
      emit_byte = 1'b0;
      field_end = 1'b0;
      raise_a   = 1'b0;
      phase1    = phase_ff;
      seen1     = seen_ff;
      err1      = err_ff;
      seen2     = seen_ff;
      err2      = err_ff;
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      err_in    = err_ff;

      // Byte step: at most one result.
      if (!empty_ff && !err_ff) begin
         unique case (phase_ff)
            PH_PLAIN: begin
               if (char_ff == CH_COMMA) begin
                  field_end = 1'b1;
                  phase1    = PH_START;
               end else begin
                  emit_byte = 1'b1;
               end
            end
            PH_QUOTED: begin
               if (char_ff == CH_QUOTE) begin
                  phase1 = PH_QSEEN;
               end else begin
                  emit_byte = 1'b1;
               end
            end
            PH_QSEEN: begin
               if (char_ff == CH_QUOTE) begin
                  emit_byte = 1'b1;
                  phase1    = PH_QUOTED;
               end else if (char_ff == CH_SPACE) begin
                  phase1 = PH_CLOSED;
               end else if (char_ff == CH_COMMA) begin
                  field_end = 1'b1;
                  phase1    = PH_START;
               end else begin
                  raise_a = 1'b1;
               end
            end
            PH_CLOSED: begin
               if (char_ff == CH_COMMA) begin
                  field_end = 1'b1;
                  phase1    = PH_START;
               end else if (char_ff != CH_SPACE) begin
                  raise_a = 1'b1;
               end
            end
            default: begin
               if (char_ff == CH_COMMA) begin
                  field_end = 1'b1;
               end else if (char_ff == CH_QUOTE) begin
                  phase1 = PH_QUOTED;
               end else begin
                  emit_byte = 1'b1;
                  phase1    = PH_PLAIN;
               end
            end
         endcase
      end

      if (emit_byte) begin
         a_vld              = 1'b1;
         res_a.byte_valid   = 1'b1;
         res_a.byte_out     = char_ff;
         res_a.field_number = seen_ff;
      end else if (raise_a || (field_end && seen_ff >= max_fields)) begin
         a_vld              = 1'b1;
         res_a.parse_error  = 1'b1;
         res_a.field_number = seen_ff;
         err1               = 1'b1;
      end else if (field_end) begin
         seen1              = seen_ff + 8'd1;
         a_vld              = 1'b1;
         res_a.field_done   = 1'b1;
         res_a.field_number = seen1;
      end

      seen2 = seen1;
      err2  = err1;

      if (empty_ff || last_ff) begin
         // Line end: close the open field, or report the failure.
         if (err1) begin
            if (!a_vld) begin
               b_vld              = 1'b1;
               res_b.parse_error  = 1'b1;
               res_b.field_number = seen1;
            end
         end else if (phase1 == PH_QUOTED || seen1 >= max_fields) begin
            b_vld              = 1'b1;
            res_b.parse_error  = 1'b1;
            res_b.field_number = seen1;
            err2               = 1'b1;
         end else begin
            seen2 = seen1 + 8'd1;
            // The last content byte carries the field end when it can.
            if (a_vld && res_a.byte_valid && !res_a.field_done && !res_a.parse_error) begin
               res_a.field_done   = 1'b1;
               res_a.field_number = seen2;
            end else begin
               b_vld              = 1'b1;
               res_b.field_done   = 1'b1;
               res_b.field_number = seen2;
            end
         end
         if (b_vld) begin
            res_b.line_done = 1'b1;
            if (err2) begin
               res_b.parse_error = 1'b1;
            end
         end else if (a_vld) begin
            res_a.line_done = 1'b1;
            if (err2) begin
               res_a.parse_error = 1'b1;
            end
         end
         phase_in = PH_START;
         seen_in  = 8'd0;
         err_in   = 1'b0;
      end else begin
         phase_in = phase1;
         seen_in  = seen1;
         err_in   = err1;
      end
   end

   assign num  = {1'b0, a_vld} + {1'b0, b_vld};
   assign fire = stage_valid_ff && ({{(RSP_CNT_W-2){1'b0}}, num} <= rsp_space);
   assign take = req_valid && req_ready;

   assign req_ready      = !stage_valid_ff || fire;
   assign stage_valid_in = take || (stage_valid_ff && !fire);

   always_comb begin
      push.num    = fire ? num : 2'd0;
      push.first  = a_vld ? res_a : res_b;
      push.second = res_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         phase_ff       <= PH_START;
         seen_ff        <= 8'd0;
         err_ff         <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            seen_ff  <= seen_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         char_ff  <= req_char_in;
         last_ff  <= req_line_last;
         empty_ff <= req_empty_line;
      end
   end

endmodule

`default_nettype wire

>>> sv/csvp_rsp_queue.sv
// Result queue: takes up to two results per cycle and hands out one beat per
// cycle while rsp_ready is high. Depends on csvp_pkg.
`default_nettype none

module csvp_rsp_queue (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  csvp_pkg::push_type       push,
   output logic [csvp_pkg::RSP_CNT_W-1:0] rsp_space,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output csvp_pkg::result_type           rsp_data
);
   import csvp_pkg::*;

   result_type           entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_PTR_W-1:0] wr_next;
   logic                 pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign rsp_space = RSP_CNT_W'(RSP_DEPTH) - count_ff;
   assign wr_next   = wr_ptr_ff + RSP_PTR_W'(1);

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.num);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push.num) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire
